>>> hw/rtl/hbq_pkg.sv
package hbq_pkg;

    localparam int HBQ_CAPACITY = 64;
    localparam int KEY_W        = 32;
    localparam int TAG_W        = 16;
    localparam int CNT_W        = 7;

    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_REMOVE = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        CMP_UP = 1'b0,
        CMP_DN = 1'b1
    } t_cmp_mode;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } t_entry;

    typedef struct packed {
        t_action          action;
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } t_in;

    typedef struct packed {
        logic             top_valid;
        logic [KEY_W-1:0] top_key;
        logic [TAG_W-1:0] top_tag;
        logic [CNT_W-1:0] entry_count;
        t_status          status;
    } t_out;

    // decision of the shared compare unit
    typedef struct packed {
        logic move;
        logic take_right;
    } t_cmp_res;

endpackage

>>> hw/rtl/hbq_store.sv
module hbq_store
    import hbq_pkg::*;
#(
    parameter int DEPTH = HBQ_CAPACITY
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  t_entry                   i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_ra_addr,
    input  logic [$clog2(DEPTH)-1:0] i_rb_addr,
    output t_entry                   o_ra_data,
    output t_entry                   o_rb_data
);

    t_entry r_mem [DEPTH];
    t_entry r_ra_data;
    t_entry r_rb_data;

    // one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_ra_data <= r_mem[i_ra_addr];
        r_rb_data <= r_mem[i_rb_addr];
    end

    assign o_ra_data = r_ra_data;
    assign o_rb_data = r_rb_data;

endmodule

>>> hw/rtl/hbq_cmp.sv
module hbq_cmp
    import hbq_pkg::*;
(
    input  t_cmp_mode i_mode,
    input  t_entry    i_cur,
    input  t_entry    i_a,
    input  t_entry    i_b,
    input  logic      i_b_ok,
    output t_cmp_res  o_res
);

    logic   w_right;
    t_entry w_pick;

    // up: a is the parent; down: a is the left child, b the right child
    always_comb begin
        w_right = (i_mode == CMP_DN) && i_b_ok && (i_b.key > i_a.key);
        w_pick  = w_right ? i_b : i_a;
        o_res.take_right = w_right;
        unique case (i_mode)
            CMP_UP:  o_res.move = i_a.key < i_cur.key;
            CMP_DN:  o_res.move = i_cur.key < w_pick.key;
            default: o_res.move = 1'b0;
        endcase
    end

endmodule

>>> hw/rtl/binary_max_heap_queue.sv
// binary max-heap priority queue of up to CAPACITY entries (32-bit key, 16-bit tag).
// an insert transaction places the entry at the end of the heap and walks it toward
// the root while its key is strictly greater than its parent's; a remove transaction
// takes the last entry to the root and walks it down, choosing the right child only
// when its key is strictly greater than the left child's. the moving entry is held in
// a register and each level has a read state, which reads the heap memory (parent, or
// both children at once), and a compare state, where the shared compare unit decides
// and writes one entry back. a flagged transaction (remove on empty, insert on full)
// leaves the store untouched and goes straight to the done state; the input is not ready
// while a transaction is being worked. each transaction returns one result with the
// root entry, the count and a status. the result sits in an output register, so the
// sequencer can work the next transaction while a result waits, holding its own result
// until the output register is free. no clearing pass is needed after reset.
module binary_max_heap_queue
    import hbq_pkg::*;
#(
    parameter int CAPACITY = HBQ_CAPACITY
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    localparam int AW = $clog2(CAPACITY);     // heap address width
    localparam int CW = $clog2(CAPACITY + 1); // fill count width
    localparam int IW = AW + 2;               // child index width

    // sequencer states
    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_UP_RD   = 7'b0000010,
        S_UP_CMP  = 7'b0000100,
        S_DN_LAST = 7'b0001000,
        S_DN_RD   = 7'b0010000,
        S_DN_CMP  = 7'b0100000,
        S_DONE    = 7'b1000000
    } t_state;

    t_state         r_state, n_state;
    logic [CW-1:0]  r_count, n_count;
    logic [AW-1:0]  r_pos, n_pos;
    t_entry         r_cur, n_cur;
    t_entry         r_top, n_top;
    logic           r_load, n_load;
    t_status        r_status, n_status;
    logic           r_out_valid;
    t_out           r_out;

    // memory port controls
    logic           w_we;
    logic [AW-1:0]  w_waddr;
    t_entry         w_wdata;
    logic [AW-1:0]  w_ra_addr;
    logic [AW-1:0]  w_rb_addr;
    t_entry         w_rd_a;
    t_entry         w_rd_b;

    // index math
    logic [AW-1:0]  w_parent;
    logic [IW-1:0]  w_left;
    logic [IW-1:0]  w_right;
    logic [IW-1:0]  w_cnt_x;
    logic           w_right_ok;

    // compare unit
    t_cmp_mode      w_mode;
    t_cmp_res       w_cmp;
    t_entry         w_pick;
    logic [AW-1:0]  w_pick_idx;
    t_entry         w_dn_cur;

    logic           w_in_acc;
    logic           w_emit;

    assign w_parent   = (r_pos - AW'(1)) >> 1;
    assign w_left     = {1'b0, r_pos, 1'b1};
    assign w_right    = w_left + IW'(1);
    assign w_cnt_x    = IW'(r_count);
    assign w_right_ok = w_right < w_cnt_x;

    assign w_mode     = (r_state == S_UP_CMP) ? CMP_UP : CMP_DN;
    assign w_pick     = w_cmp.take_right ? w_rd_b : w_rd_a;
    assign w_pick_idx = w_cmp.take_right ? w_right[AW-1:0] : w_left[AW-1:0];

    // first level of a remove takes the moving entry straight from the read port
    assign w_dn_cur   = r_load ? w_rd_a : r_cur;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;

    // result can be loaded when the output register is free or being drained
    assign w_emit     = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    hbq_store #(
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_ra_addr (w_ra_addr),
        .i_rb_addr (w_rb_addr),
        .o_ra_data (w_rd_a),
        .o_rb_data (w_rd_b)
    );

    hbq_cmp u_cmp (
        .i_mode (w_mode),
        .i_cur  (r_cur),
        .i_a    (w_rd_a),
        .i_b    (w_rd_b),
        .i_b_ok (w_right_ok),
        .o_res  (w_cmp)
    );

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_pos     = r_pos;
        n_cur     = r_cur;
        n_load    = r_load;
        n_status  = r_status;
        w_we      = 1'b0;
        w_waddr   = r_pos;
        w_wdata   = r_cur;
        w_ra_addr = w_parent;
        w_rb_addr = w_parent;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_status = ST_OK;
                    if (i_in_data.action == ACT_INSERT) begin
                        if (r_count == CW'(CAPACITY)) begin
                            // full: entry dropped, store untouched
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_cur.key = i_in_data.key;
                            n_cur.tag = i_in_data.tag;
                            n_pos     = AW'(r_count);
                            n_count   = r_count + CW'(1);
                            n_state   = S_UP_RD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            n_count = r_count - CW'(1);
                            n_pos   = '0;
                            n_state = S_DN_LAST;
                        end
                    end
                end
            end
            S_UP_RD: begin
                if (r_pos == '0) begin
                    w_we    = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                w_we = 1'b1;
                if (w_cmp.move) begin
                    // parent drops into the hole, hole moves up
                    w_wdata = w_rd_a;
                    n_pos   = w_parent;
                    n_state = S_UP_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DN_LAST: begin
                // count already holds the index of the old last slot
                w_ra_addr = AW'(r_count);
                n_load    = 1'b1;
                n_state   = S_DN_RD;
            end
            S_DN_RD: begin
                n_cur     = w_dn_cur;
                n_load    = 1'b0;
                w_ra_addr = w_left[AW-1:0];
                w_rb_addr = w_right[AW-1:0];
                if (w_left >= w_cnt_x) begin
                    w_we    = 1'b1;
                    w_wdata = w_dn_cur;
                    n_state = S_DONE;
                end else begin
                    n_state = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                w_we = 1'b1;
                if (w_cmp.move) begin
                    // larger child moves up, hole moves down
                    w_wdata = w_pick;
                    n_pos   = w_pick_idx;
                    n_state = S_DN_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_emit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // shadow copy of the root, updated on every write to slot zero
    assign n_top = (w_we && (w_waddr == '0)) ? w_wdata : r_top;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_load      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_load  <= n_load;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_cur    <= n_cur;
        r_top    <= n_top;
        r_status <= n_status;
        if (w_emit) begin
            r_out.top_valid   <= (r_count != '0);
            r_out.top_key     <= (r_count != '0) ? r_top.key : '0;
            r_out.top_tag     <= (r_count != '0) ? r_top.tag : '0;
            r_out.entry_count <= CNT_W'(r_count);
            r_out.status      <= r_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> hw/rtl/hbq_checker.sv
module hbq_checker
    import hbq_pkg::*;
#(
    parameter int CAPACITY = HBQ_CAPACITY
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    // one transaction at a time: ready drops right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready after accept");

    // an empty heap reports zero root fields
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.top_valid) |->
        (o_out_data.top_key == '0 && o_out_data.top_tag == '0))
        else $error("nonzero root on empty heap");

    // with CAPACITY up to 127, top_valid agrees with the count and the count stays in range
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((CAPACITY > 127) ||
        ((o_out_data.top_valid == (o_out_data.entry_count != '0)) &&
         (o_out_data.entry_count <= CNT_W'(CAPACITY)))))
        else $error("entry count inconsistent");

    // a remove on empty leaves the heap empty
    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == ST_EMPTY) |->
        (!o_out_data.top_valid && o_out_data.entry_count == '0))
        else $error("remove on empty with entries");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("result changed while stalled");

endmodule

bind binary_max_heap_queue hbq_checker #(
    .CAPACITY (CAPACITY)
) u_hbq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

>>> sim/binary_max_heap_queue_test.sv
`timescale 1ns / 1ps

module binary_max_heap_queue_test
    import hbq_pkg::*;
();

    localparam int DEPTH       = HBQ_CAPACITY;
    localparam int STALL_LIMIT = 5000;
    localparam int PHASES      = 15;
    localparam int PHASE_ITEMS = 100;

    // shadow heap: predicts the root, count and status of every transaction
    class heap_scoreboard;
        logic [KEY_W-1:0] keys [DEPTH];
        logic [TAG_W-1:0] tags [DEPTH];
        int unsigned fill          = 0;
        int unsigned deepest       = 0;
        int unsigned mismatches    = 0;
        int unsigned requests      = 0;
        int unsigned results_seen  = 0;
        int unsigned empty_removes = 0;
        int unsigned full_inserts  = 0;
        t_out expected_tops [$];

        function void exchange(int a, int b);
            logic [KEY_W-1:0] k;
            logic [TAG_W-1:0] t;
            k = keys[a];
            t = tags[a];
            keys[a] = keys[b];
            tags[a] = tags[b];
            keys[b] = k;
            tags[b] = t;
        endfunction

        function void note_request(t_in req);
            t_out r;
            int   pos;
            int   parent;
            int   pick;
            r = '0;
            r.status = ST_OK;
            requests++;
            if (req.action == ACT_INSERT) begin
                if (fill >= DEPTH) begin
                    r.status = ST_FULL;
                    full_inserts++;
                end else begin
                    pos = fill;
                    keys[pos] = req.key;
                    tags[pos] = req.tag;
                    fill++;
                    // walk up while strictly greater than the parent
                    while (pos > 0) begin
                        parent = (pos - 1) / 2;
                        if (keys[pos] > keys[parent]) begin
                            exchange(pos, parent);
                            pos = parent;
                        end else begin
                            break;
                        end
                    end
                end
            end else begin
                if (fill == 0) begin
                    r.status = ST_EMPTY;
                    empty_removes++;
                end else begin
                    keys[0] = keys[fill-1];
                    tags[0] = tags[fill-1];
                    fill--;
                    pos = 0;
                    // right child only if strictly greater, swap only if strictly smaller
                    while (2 * pos + 1 < fill) begin
                        pick = 2 * pos + 1;
                        if (pick + 1 < fill && keys[pick+1] > keys[pick])
                            pick = pick + 1;
                        if (keys[pos] < keys[pick]) begin
                            exchange(pos, pick);
                            pos = pick;
                        end else begin
                            break;
                        end
                    end
                end
            end
            if (fill > deepest)
                deepest = fill;
            r.top_valid   = (fill > 0);
            r.top_key     = (fill > 0) ? keys[0] : '0;
            r.top_tag     = (fill > 0) ? tags[0] : '0;
            r.entry_count = CNT_W'(fill);
            expected_tops = {expected_tops, r};
        endfunction

        function void report_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
            end
        endfunction

        function void check_report(t_out got);
            t_out want;
            results_seen++;
            if (expected_tops.size() == 0) begin
                mismatches++;
                $display("%0t: result with nothing pending, expected none, actual %p",
                         $time, got);
                return;
            end
            want = expected_tops.pop_front();
            report_field("top_valid", want.top_valid, got.top_valid);
            report_field("top_key", want.top_key, got.top_key);
            report_field("top_tag", want.top_tag, got.top_tag);
            report_field("entry_count", want.entry_count, got.entry_count);
            report_field("status", want.status, got.status);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic o_in_ready;
    t_in  i_in_data   = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out_data;

    heap_scoreboard sb;
    int in_gap_max  = 10;
    int out_gap_max = 10;
    int out_hold    = 0;

    binary_max_heap_queue #(
        .CAPACITY(DEPTH)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // values read right after the edge are the ones the block saw
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                sb.note_request(i_in_data);
            if (o_out_valid && i_out_ready)
                sb.check_report(o_out_data);
        end
    end

    // watchdog on cycles with no transaction on either side
    initial begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("binary_max_heap_queue_test failed");
        $finish;
    end

    // result side: random gaps, plus a long hold-off when one is requested
    initial begin
        int idle;
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            idle = $urandom_range(0, out_gap_max) + out_hold;
            out_hold = 0;
            if (idle > 0) begin
                i_out_ready <= 1'b0;
                repeat (idle) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    function automatic t_in make_req(t_action act, logic [KEY_W-1:0] k, logic [TAG_W-1:0] t);
        t_in r;
        r.action = act;
        r.key    = k;
        r.tag    = t;
        return r;
    endfunction

    // keys drawn to hit ties and both extremes often
    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return KEY_W'($urandom_range(0, 7));
            3:       return '1 - KEY_W'($urandom_range(0, 3));
            default: return KEY_W'($urandom);
        endcase
    endfunction

    // valid stays high across back-to-back items, lowered only before a gap
    task automatic send_item(t_in item);
        int gap;
        gap = $urandom_range(0, in_gap_max);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic insert_entry(logic [KEY_W-1:0] k, logic [TAG_W-1:0] t);
        send_item(make_req(ACT_INSERT, k, t));
    endtask

    task automatic remove_top();
        send_item(make_req(ACT_REMOVE, KEY_W'($urandom), TAG_W'($urandom)));
    endtask

    // stop offering so the last item is not taken again while waiting
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_tops.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        int mix [PHASES];
        int n;
        t_action act;
        mix = '{60, 95, 95, 5, 50, 100, 0, 70, 30, 50, 90, 10, 55, 100, 0};
        sb = new;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: remove on empty, key extremes, ties, equal children
        remove_top();
        insert_entry('0, '0);
        insert_entry('1, '1);
        insert_entry(32'd5, 16'h0001);
        insert_entry(32'd5, 16'h0002);
        insert_entry('1, 16'h0003);
        remove_top();
        remove_top();
        remove_top();
        remove_top();
        remove_top();
        remove_top();
        insert_entry(32'd100, 16'h00a0);
        insert_entry(32'd50, 16'h00b0);
        insert_entry(32'd50, 16'h00c0);
        insert_entry(32'd10, 16'h00d0);
        insert_entry(32'd100, 16'h00e0);
        // last entry to root, equal children, left one must rise
        remove_top();
        remove_top();
        remove_top();
        remove_top();
        remove_top();
        remove_top();
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            case (p % 4)
                0: begin in_gap_max = 0;  out_gap_max = 0;  end
                1: begin in_gap_max = 10; out_gap_max = 10; end
                2: begin in_gap_max = 0;  out_gap_max = 10; end
                default: begin in_gap_max = 10; out_gap_max = 0; end
            endcase
            // back up the result side so the block stalls its input
            if (p == 5 || p == 13)
                out_hold = 400;
            // sender goes quiet until every result is back
            if (p == 9)
                wait_drained();
            n = PHASE_ITEMS;
            for (int i = 0; i < n; i++) begin
                act = ($urandom_range(0, 99) < mix[p]) ? ACT_INSERT : ACT_REMOVE;
                if (act == ACT_INSERT)
                    insert_entry(pick_key(), TAG_W'($urandom));
                else
                    remove_top();
            end
        end

        @(posedge i_clk);
        i_in_valid <= 1'b0;
        wait_drained();
        repeat (40) @(posedge i_clk);

        $display("covered %0d transactions and %0d results, deepest fill %0d of %0d",
                 sb.requests, sb.results_seen, sb.deepest, DEPTH);
        $display("flagged: %0d removes on empty, %0d inserts on full, %0d mismatches",
                 sb.empty_removes, sb.full_inserts, sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_tops.size() == 0) begin
            $display("binary_max_heap_queue_test passed");
        end else begin
            if (sb.expected_tops.size() != 0)
                $display("%0t: %0d results never arrived", $time, sb.expected_tops.size());
            $display("binary_max_heap_queue_test failed");
        end
        $finish;
    end

endmodule

>>> binary_max_heap_queue.f
hw/rtl/hbq_pkg.sv
hw/rtl/hbq_store.sv
hw/rtl/hbq_cmp.sv
hw/rtl/binary_max_heap_queue.sv
hw/rtl/hbq_checker.sv
sim/binary_max_heap_queue_test.sv
